// ----- sv/swarq_pkg.sv -----
// shared types, constants and microprogram of the sliding-window arq sender
`timescale 1ns / 1ps

package swarq_pkg;

	// field widths
	localparam int ACT_W      = 2;
	localparam int SEQ_W      = 4;
	localparam int IDX_W      = 16;
	localparam int TICK_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_WINDOW = 8;

	// action codes
	localparam logic [ACT_W-1:0] ACT_START = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SEGMENTS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;

	localparam logic [IDX_W-1:0] TIMEOUT_RST = 16'd1000;

	// microprogram
	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_FETCH,
		OP_TICK,
		OP_TICK_SETUP,
		OP_EMIT,
		OP_REPORT,
		OP_START,
		OP_ACK_SETUP,
		OP_ADV,
		OP_ADV_LOOP,
		OP_ACK_MARK
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_IS_START,
		C_IS_ACK,
		C_NOT_TICK,
		C_NO_TIMEOUT,
		C_RUN_END,
		C_ACK_IGNORE,
		C_ACK_NOT_BASE
	} cond_t;

	typedef struct packed {
		uop_t            uop;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// status from the datapath into the sequencer
	typedef struct packed {
		logic no_item;
		logic is_start;
		logic is_ack;
		logic not_tick;
		logic no_timeout;
		logic run_end;
		logic ack_ignore;
		logic ack_not_base;
		logic hold;
	} seq_flags_t;

	localparam logic [PC_W-1:0] A_FETCH    = 4'd0;
	localparam logic [PC_W-1:0] A_DISP0    = 4'd1;
	localparam logic [PC_W-1:0] A_DISP1    = 4'd2;
	localparam logic [PC_W-1:0] A_DISP2    = 4'd3;
	localparam logic [PC_W-1:0] A_TICK     = 4'd4;
	localparam logic [PC_W-1:0] A_TICK_CHK = 4'd5;
	localparam logic [PC_W-1:0] A_RUN      = 4'd6;
	localparam logic [PC_W-1:0] A_REPORT   = 4'd7;
	localparam logic [PC_W-1:0] A_START    = 4'd8;
	localparam logic [PC_W-1:0] A_ACK      = 4'd9;
	localparam logic [PC_W-1:0] A_ACK_BASE = 4'd10;
	localparam logic [PC_W-1:0] A_ADV      = 4'd11;
	localparam logic [PC_W-1:0] A_ADV_LOOP = 4'd12;
	localparam logic [PC_W-1:0] A_MARK     = 4'd13;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		unique case (pc)
			A_FETCH:    w = '{OP_FETCH,      C_NO_ITEM,      A_FETCH};
			A_DISP0:    w = '{OP_NOP,        C_IS_START,     A_START};
			A_DISP1:    w = '{OP_NOP,        C_IS_ACK,       A_ACK};
			A_DISP2:    w = '{OP_NOP,        C_NOT_TICK,     A_FETCH};
			A_TICK:     w = '{OP_TICK,       C_NEVER,        A_FETCH};
			A_TICK_CHK: w = '{OP_TICK_SETUP, C_NO_TIMEOUT,   A_FETCH};
			A_RUN:      w = '{OP_EMIT,       C_RUN_END,      A_REPORT};
			A_REPORT:   w = '{OP_REPORT,     C_ALWAYS,       A_FETCH};
			A_START:    w = '{OP_START,      C_ALWAYS,       A_RUN};
			A_ACK:      w = '{OP_ACK_SETUP,  C_ACK_IGNORE,   A_FETCH};
			A_ACK_BASE: w = '{OP_NOP,        C_ACK_NOT_BASE, A_MARK};
			A_ADV:      w = '{OP_ADV,        C_NEVER,        A_FETCH};
			A_ADV_LOOP: w = '{OP_ADV_LOOP,   C_ALWAYS,       A_RUN};
			A_MARK:     w = '{OP_ACK_MARK,   C_ALWAYS,       A_FETCH};
			default:    w = '{OP_NOP,        C_ALWAYS,       A_FETCH};
		endcase
		return w;
	endfunction

endpackage

// ----- sv/swarq_if.sv -----
// channel interfaces: input events, send commands, configuration writes
`timescale 1ns / 1ps

interface swarq_evt_if
	import swarq_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [SEQ_W-1:0] ack_seq;

	modport source (output valid, output action, output ack_seq, input ready);
	modport sink (input valid, input action, input ack_seq, output ready);
endinterface

interface swarq_cmd_if
	import swarq_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] send_index;
	logic [SEQ_W-1:0] send_seq;
	logic             is_resend;
	logic             last;
	logic             all_acked;

	modport source (output valid, output send_index, output send_seq, output is_resend,
		output last, output all_acked, input ready);
	modport sink (input valid, input send_index, input send_seq, input is_resend,
		input last, input all_acked, output ready);
endinterface

interface swarq_cfg_if
	import swarq_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/swarq_useq.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps

module swarq_useq
	import swarq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  seq_flags_t flags,
	output ctrl_t      ctrl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctrl = ucode(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:        take = 1'b0;
			C_ALWAYS:       take = 1'b1;
			C_NO_ITEM:      take = flags.no_item;
			C_IS_START:     take = flags.is_start;
			C_IS_ACK:       take = flags.is_ack;
			C_NOT_TICK:     take = flags.not_tick;
			C_NO_TIMEOUT:   take = flags.no_timeout;
			C_RUN_END:      take = flags.run_end;
			C_ACK_IGNORE:   take = flags.ack_ignore;
			C_ACK_NOT_BASE: take = flags.ack_not_base;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_FETCH;
		end else if (flags.hold) begin
			pc_q <= pc_q;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

// ----- sv/sliding_window_arq_sender.sv -----
// top level of the sliding-window arq sender: datapath around a microcoded sequencer
//
//   channel | dir | payload                                          | handshake
//   evt     | in  | action, ack_seq                                  | valid / ready
//   cmd     | out | send_index, send_seq, is_resend, last, all_acked | valid / ready
//   cfg     | in  | index, data                                      | valid / ready
//
// one event at a time; a start sends up to WINDOW segments, a tick advances the tick
// clock and on timeout resends the window from the base, an ack of the base advances
// the base over acked slots and sends the segments that this admits, and another
// in-window ack marks its slot; ignored acks and unknown actions send nothing
// the sequencer issues at most one send per cycle through a single output register;
// it holds its step while the output register is full and not being taken
// arst_n clears the window, bitmap, send times and tick clock; cfg is always ready
`timescale 1ns / 1ps

module sliding_window_arq_sender
	import swarq_pkg::*;
#(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic clk,
	input  logic arst_n,
	swarq_evt_if.sink   evt,
	swarq_cmd_if.source cmd,
	swarq_cfg_if.sink   cfg
);

	localparam int SLOTS  = WINDOW + 1;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SW     = ((SLOT_W > SEQ_W) ? SLOT_W : SEQ_W) + 1;
	localparam int RIDX_W = IDX_W + 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);

	// configuration
	logic [IDX_W-1:0] total_q;
	logic [IDX_W-1:0] timeout_q;

	// window state
	logic              running_q;
	logic [IDX_W-1:0]  base_q;
	logic [SLOT_W-1:0] base_seq_q;
	logic [SLOTS-1:0]  acked_q;
	logic [TICK_W-1:0] sent_tick_q [SLOTS];
	logic [TICK_W-1:0] tick_q;

	// latched event
	logic [ACT_W-1:0] act_q;
	logic [SEQ_W-1:0] seq_q;

	// send run registers
	logic [RIDX_W-1:0] run_idx_q;
	logic [SLOT_W-1:0] run_seq_q;
	logic [CNT_W-1:0]  run_cnt_q;
	logic              resend_q;
	logic              report_q;
	logic              emitted_q;

	// output register
	logic             cmd_valid_q;
	logic [IDX_W-1:0] cmd_index_q;
	logic [SEQ_W-1:0] cmd_seq_q;
	logic             cmd_resend_q;
	logic             cmd_last_q;
	logic             cmd_done_q;

	ctrl_t      ctrl;
	seq_flags_t flags;

	logic              finished;
	logic [SW-1:0]     seq_ext;
	logic              seq_bad;
	logic [SLOT_W-1:0] seq_slot;
	logic [TICK_W-1:0] age;
	logic              timed_out;
	logic              run_end;
	logic [RIDX_W-1:0] run_idx_nx;
	logic              run_last;
	logic [SLOT_W-1:0] run_seq_inc;
	logic [SLOT_W-1:0] base_seq_inc;
	logic [SLOT_W-1:0] ack_run_seq;
	logic              out_free;
	logic              adv_more;
	logic              rep_need;
	logic [SLOT_W:0]   delta;
	logic              mark_ok;
	logic              emit_run;
	logic              emit_rep;
	logic              do_adv;

	swarq_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign cfg.ready = 1'b1;
	assign evt.ready = (ctrl.uop == OP_FETCH);

	assign finished = (base_q >= total_q);

	// ack sequence number widened so out-of-range codes compare correctly
	assign seq_ext  = SW'(seq_q);
	assign seq_bad  = (seq_ext >= SW'(SLOTS));
	assign seq_slot = seq_ext[SLOT_W-1:0];

	// age of the base segment, wraps mod 2^32
	assign age       = tick_q - sent_tick_q[base_seq_q];
	assign timed_out = (age > TICK_W'(timeout_q));

	// run stops after its count or at the end of the transfer
	assign run_end    = (run_cnt_q == '0) || (run_idx_q >= RIDX_W'(total_q));
	assign run_idx_nx = run_idx_q + RIDX_W'(1);
	assign run_last   = (run_cnt_q == CNT_W'(1)) || (run_idx_nx >= RIDX_W'(total_q));

	assign run_seq_inc  = (run_seq_q == LAST_SLOT) ? '0 : run_seq_q + SLOT_W'(1);
	assign base_seq_inc = (base_seq_q == LAST_SLOT) ? '0 : base_seq_q + SLOT_W'(1);
	// sequence of base + WINDOW, i.e. one slot behind the base
	assign ack_run_seq  = (base_seq_q == '0) ? LAST_SLOT : base_seq_q - SLOT_W'(1);

	assign out_free = !cmd_valid_q || cmd.ready;
	assign adv_more = (base_q < total_q) && acked_q[base_seq_q];
	assign rep_need = report_q && !emitted_q && finished;

	// offset of an ack from the base slot, modulo the slot count
	always_comb begin
		if (seq_slot >= base_seq_q) begin
			delta = {1'b0, seq_slot} - {1'b0, base_seq_q};
		end else begin
			delta = {1'b0, seq_slot} + (SLOT_W + 1)'(SLOTS) - {1'b0, base_seq_q};
		end
	end

	assign mark_ok = (delta < (SLOT_W + 1)'(WINDOW))
		&& (({1'b0, base_q} + RIDX_W'(delta)) < RIDX_W'(total_q));

	assign emit_run = (ctrl.uop == OP_EMIT) && !run_end && out_free;
	assign emit_rep = (ctrl.uop == OP_REPORT) && rep_need && out_free;
	assign do_adv   = (ctrl.uop == OP_ADV) || ((ctrl.uop == OP_ADV_LOOP) && adv_more);

	always_comb begin
		flags.no_item      = !evt.valid;
		flags.is_start     = (act_q == ACT_START);
		flags.is_ack       = (act_q == ACT_ACK);
		flags.not_tick     = (act_q != ACT_TICK);
		flags.no_timeout   = !running_q || finished || !timed_out;
		flags.run_end      = run_end;
		flags.ack_ignore   = !running_q || finished || seq_bad;
		flags.ack_not_base = (seq_slot != base_seq_q);
		unique case (ctrl.uop)
			OP_EMIT:     flags.hold = !run_end;
			OP_REPORT:   flags.hold = rep_need && !out_free;
			OP_ADV_LOOP: flags.hold = adv_more;
			default:     flags.hold = 1'b0;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TOTAL_SEGMENTS: total_q   <= cfg.data;
				REG_TIMEOUT_TICKS:  timeout_q <= cfg.data;
			endcase
		end
	end

	// window state and send times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			base_q     <= '0;
			base_seq_q <= '0;
			acked_q    <= '0;
			tick_q     <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				sent_tick_q[i] <= '0;
			end
		end else begin
			case (ctrl.uop)
				OP_TICK: begin
					tick_q <= tick_q + TICK_W'(1);
				end
				OP_START: begin
					running_q  <= 1'b1;
					base_q     <= '0;
					base_seq_q <= '0;
					acked_q    <= '0;
				end
				OP_ACK_MARK: begin
					if (mark_ok) begin
						acked_q[seq_slot] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (do_adv) begin
				acked_q[base_seq_q] <= 1'b0;
				base_q              <= base_q + IDX_W'(1);
				base_seq_q          <= base_seq_inc;
			end
			if (emit_run) begin
				sent_tick_q[run_seq_q] <= tick_q;
			end
		end
	end

	// send run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_idx_q <= '0;
			run_seq_q <= '0;
			run_cnt_q <= '0;
			resend_q  <= 1'b0;
			report_q  <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			case (ctrl.uop)
				OP_START: begin
					run_idx_q <= '0;
					run_seq_q <= '0;
					run_cnt_q <= CNT_FULL;
					resend_q  <= 1'b0;
					report_q  <= 1'b1;
					emitted_q <= 1'b0;
				end
				OP_TICK_SETUP: begin
					// resend the whole window from the base
					run_idx_q <= RIDX_W'(base_q);
					run_seq_q <= base_seq_q;
					run_cnt_q <= CNT_FULL;
					resend_q  <= 1'b1;
					report_q  <= 1'b0;
					emitted_q <= 1'b0;
				end
				OP_ACK_SETUP: begin
					// newly admitted segments start one window past the old base
					run_idx_q <= RIDX_W'(base_q) + RIDX_W'(WINDOW);
					run_seq_q <= ack_run_seq;
					run_cnt_q <= '0;
					resend_q  <= 1'b0;
					report_q  <= 1'b1;
					emitted_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (do_adv) begin
				run_cnt_q <= run_cnt_q + CNT_W'(1);
			end
			if (emit_run) begin
				run_idx_q <= run_idx_nx;
				run_seq_q <= run_seq_inc;
				run_cnt_q <= run_cnt_q - CNT_W'(1);
				emitted_q <= 1'b1;
			end
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			act_q <= evt.action;
			seq_q <= evt.ack_seq;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (emit_run || emit_rep) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_run) begin
			cmd_index_q  <= run_idx_q[IDX_W-1:0];
			cmd_seq_q    <= SEQ_W'(run_seq_q);
			cmd_resend_q <= resend_q;
			cmd_last_q   <= run_last;
			cmd_done_q   <= finished;
		end else if (emit_rep) begin
			// completion report
			cmd_index_q  <= '0;
			cmd_seq_q    <= '0;
			cmd_resend_q <= 1'b0;
			cmd_last_q   <= 1'b1;
			cmd_done_q   <= 1'b1;
		end
	end

	assign cmd.valid      = cmd_valid_q;
	assign cmd.send_index = cmd_index_q;
	assign cmd.send_seq   = cmd_seq_q;
	assign cmd.is_resend  = cmd_resend_q;
	assign cmd.last       = cmd_last_q;
	assign cmd.all_acked  = cmd_done_q;

`ifndef SYNTHESIS
	// one event at a time: the fetch step is left right after a transaction
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("event accepted twice in a row");

	// a timeout resend never reports a finished transfer
	a_resend_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.is_resend |-> !cmd.all_acked)
		else $error("resend flagged as all acked");

	// base slot stays within the slot count
	a_base_slot: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, base_seq_q} < (SLOT_W + 1)'(SLOTS))
		else $error("base slot out of range");
`endif

endmodule
